// ----- design/arup_pkg.sv -----
// Shared constants and the reciprocal table for the alpha recovery pipeline.
// No dependencies; used by arup_unpremul and alpha_recover_unpremultiply_core.
package arup_pkg;

  localparam int unsigned CH_W       = 8;
  localparam int unsigned CH_MAX     = 255;
  // floor(x/3) == (x*DIV3_MUL) >> DIV3_SHIFT for all x up to 765
  localparam int unsigned DIV3_MUL   = 683;
  localparam int unsigned DIV3_SHIFT = 11;
  // reciprocal precision: ceil(2^RECIP_SHIFT / a), exact for numerators below 2^16
  localparam int unsigned RECIP_SHIFT = 24;
  localparam int unsigned RECIP_W     = RECIP_SHIFT + 1;
  localparam int unsigned NUM_W       = 2 * CH_W;
  localparam int unsigned QUOT_W      = NUM_W + 1;

  typedef logic [RECIP_W-1:0] recip_t;
  typedef recip_t recip_tab_t [2**CH_W];

  // Build the table by shift-subtract division at elaboration.
  // Entry 0 is 0 so a zero alpha yields a zero quotient.
  function automatic recip_tab_t build_recip();
    recip_tab_t tab;
    logic [RECIP_W:0]   rem;
    logic [RECIP_W-1:0] quo;
    logic [RECIP_W-1:0] dvd;
    tab[0] = '0;
    for (int a = 1; a < 2**CH_W; a++) begin
      rem = '0;
      quo = '0;
      dvd = RECIP_W'(1) << RECIP_SHIFT;
      for (int i = RECIP_W - 1; i >= 0; i--) begin
        rem = {rem[RECIP_W-1:0], dvd[i]};
        if (rem >= (RECIP_W+1)'(a)) begin
          rem    = rem - (RECIP_W+1)'(a);
          quo[i] = 1'b1;
        end
      end
      tab[a] = quo + RECIP_W'(rem != '0);
    end
    return tab;
  endfunction

  localparam recip_tab_t RECIP_TAB = build_recip();

endpackage

// ----- design/alpha_recover_unpremultiply_core.sv -----
// Alpha recovery from black/white renders with un-premultiplied color output.
// Throughput: one word per cycle; the five-stage pipeline advances whenever the
// output register is empty or taken, so in_stall follows out_stall only while a
// result waits.
// Reset (rst_n low, synchronous) clears all stage valid bits; data is not reset.
// Depends on arup_pkg and arup_unpremul.
module alpha_recover_unpremultiply_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [arup_pkg::CH_W-1:0]  in_black_blue,
  input  logic [arup_pkg::CH_W-1:0]  in_black_green,
  input  logic [arup_pkg::CH_W-1:0]  in_black_red,
  input  logic [arup_pkg::CH_W-1:0]  in_white_blue,
  input  logic [arup_pkg::CH_W-1:0]  in_white_green,
  input  logic [arup_pkg::CH_W-1:0]  in_white_red,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [arup_pkg::CH_W-1:0]  out_blue,
  output logic [arup_pkg::CH_W-1:0]  out_green,
  output logic [arup_pkg::CH_W-1:0]  out_red,
  output logic [arup_pkg::CH_W-1:0]  out_alpha,
  output logic                       out_mask_transparent
);

  localparam int unsigned SUM_W  = arup_pkg::CH_W + 2;
  localparam int unsigned PROD_W = 2 * SUM_W;

  logic                       en;
  logic [4:0]                 vld_r, vld_nxt;
  logic [SUM_W-1:0]           wsum, bsum;
  logic [SUM_W-1:0]           pos_r, pos_nxt;
  logic [PROD_W-1:0]          d3_prod;
  logic [arup_pkg::CH_W-1:0]  transp;
  logic [arup_pkg::CH_W-1:0]  s1_bb_r, s1_bg_r, s1_br_r;
  logic [arup_pkg::CH_W-1:0]  s2_bb_r, s2_bg_r, s2_br_r;
  logic [arup_pkg::CH_W-1:0]  s2_alpha_r, s2_alpha_nxt;
  logic [arup_pkg::CH_W-1:0]  s3_alpha_r, s4_alpha_r, s5_alpha_r;

  // whole pipeline moves unless a finished word is held at the output
  assign en       = !(vld_r[4] && out_stall);
  assign in_stall = !en;
  assign vld_nxt  = {vld_r[3:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  // stage 1: positive part of white-minus-black sum
  assign wsum    = SUM_W'(in_white_blue) + SUM_W'(in_white_green) + SUM_W'(in_white_red);
  assign bsum    = SUM_W'(in_black_blue) + SUM_W'(in_black_green) + SUM_W'(in_black_red);
  assign pos_nxt = (wsum > bsum) ? (wsum - bsum) : '0;

  // stage 2: transparency = sum/3 (never above 255), alpha = 255 - transparency
  assign d3_prod      = PROD_W'(pos_r) * PROD_W'(arup_pkg::DIV3_MUL);
  assign transp       = d3_prod[arup_pkg::DIV3_SHIFT +: arup_pkg::CH_W];
  assign s2_alpha_nxt = arup_pkg::CH_W'(arup_pkg::CH_MAX) - transp;

  always_ff @(posedge clk) begin
    if (en) begin
      pos_r      <= pos_nxt;
      s1_bb_r    <= in_black_blue;
      s1_bg_r    <= in_black_green;
      s1_br_r    <= in_black_red;
      s2_alpha_r <= s2_alpha_nxt;
      s2_bb_r    <= s1_bb_r;
      s2_bg_r    <= s1_bg_r;
      s2_br_r    <= s1_br_r;
      // alpha rides alongside the divide lanes
      s3_alpha_r <= s2_alpha_r;
      s4_alpha_r <= s3_alpha_r;
      s5_alpha_r <= s4_alpha_r;
    end
  end

  // stages 3..5: per-channel divide lanes
  arup_unpremul u_blue (
    .clk     (clk),
    .en      (en),
    .alpha_i (s2_alpha_r),
    .chan_i  (s2_bb_r),
    .chan_o  (out_blue)
  );

  arup_unpremul u_green (
    .clk     (clk),
    .en      (en),
    .alpha_i (s2_alpha_r),
    .chan_i  (s2_bg_r),
    .chan_o  (out_green)
  );

  arup_unpremul u_red (
    .clk     (clk),
    .en      (en),
    .alpha_i (s2_alpha_r),
    .chan_i  (s2_br_r),
    .chan_o  (out_red)
  );

  assign out_valid            = vld_r[4];
  assign out_alpha            = s5_alpha_r;
  assign out_mask_transparent = !s5_alpha_r[arup_pkg::CH_W-1];

endmodule

// ----- design/arup_unpremul.sv -----
// One channel of the un-premultiply divide: channel*255/alpha, clamped to 255.
// Three register stages; uses arup_pkg for widths and the reciprocal table.
module arup_unpremul (
  input  logic                       clk,
  input  logic                       en,
  input  logic [arup_pkg::CH_W-1:0]  alpha_i,
  input  logic [arup_pkg::CH_W-1:0]  chan_i,
  output logic [arup_pkg::CH_W-1:0]  chan_o
);

  logic [arup_pkg::NUM_W-1:0]          num_r, num_nxt;
  arup_pkg::recip_t                    rcp_r, rcp_nxt;
  logic [arup_pkg::NUM_W+arup_pkg::RECIP_W-1:0] prod;
  logic [arup_pkg::QUOT_W-1:0]         quo_r, quo_nxt;
  logic [arup_pkg::CH_W-1:0]           res_r, res_nxt;

  // stage A: numerator c*255 and reciprocal lookup
  assign num_nxt = {chan_i, arup_pkg::CH_W'(0)} - arup_pkg::NUM_W'(chan_i);
  assign rcp_nxt = arup_pkg::RECIP_TAB[alpha_i];

  // stage B: multiply by reciprocal, keep integer part
  assign prod    = arup_pkg::NUM_W'(num_r) * rcp_r;
  assign quo_nxt = prod[arup_pkg::RECIP_SHIFT +: arup_pkg::QUOT_W];

  // stage C: clamp to channel max
  assign res_nxt = (quo_r > arup_pkg::QUOT_W'(arup_pkg::CH_MAX)) ?
                   arup_pkg::CH_W'(arup_pkg::CH_MAX) : quo_r[arup_pkg::CH_W-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      num_r <= num_nxt;
      rcp_r <= rcp_nxt;
      quo_r <= quo_nxt;
      res_r <= res_nxt;
    end
  end

  assign chan_o = res_r;

endmodule
